### rtl/core/cholesky_solve_inverse_core_macros.svh
// Assertion macros shared by the Cholesky core modules.
`ifndef CHOLESKY_SOLVE_INVERSE_CORE_MACROS_SVH
`define CHOLESKY_SOLVE_INVERSE_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define CSI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define CSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/csi_pkg.sv
// Shared types, codes and defaults of the Cholesky solve and inverse core.
`timescale 1ns / 1ps
package csi_pkg;

  localparam int MAX_SIZE_DEF  = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [3:0] SIZE_RESET = 4'd8;
  localparam logic REG_SIZE = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_INVERSE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_REPORT   = 2'd0,
    KIND_SOLUTION = 2'd1,
    KIND_INVERSE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PIVOT     = 2'd1,
    ST_NO_FACTOR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    INIT_FB    = 2'd0,
    INIT_V     = 2'd1,
    INIT_S     = 2'd2,
    INIT_CONST = 2'd3
  } init_sel_e;

  typedef enum logic [1:0] {
    Y_FB = 2'd0,
    Y_V  = 2'd1,
    Y_S  = 2'd2
  } y_sel_e;

  typedef enum logic [1:0] {
    MUL_XY       = 2'd0,
    MUL_DET_ROOT = 2'd1,
    MUL_DET_SQ   = 2'd2
  } mul_sel_e;

  typedef enum logic [1:0] {
    OUT_ZERO = 2'd0,
    OUT_PROD = 2'd1,
    OUT_VEC  = 2'd2,
    OUT_INV  = 2'd3
  } out_sel_e;

  typedef struct packed {
    logic      acc_load;
    init_sel_e init_sel;
    logic      init_one;
    logic      den_load;
    logic      mul_en;
    mul_sel_e  mul_sel;
    y_sel_e    y_sel;
    logic      acc_mac;
    logic      root_start;
    logic      div_start;
    logic      det_init;
    logic      det_update;
    logic      f_we;
    logic      v_we;
    logic      s_we;
    logic      wr_input;
    logic      out_load;
    kind_e     out_kind;
    status_e   out_status;
    out_sel_e  out_sel;
    logic      out_end;
  } csi_cmd_t;

  typedef struct packed {
    logic unit_busy;
    logic acc_nonpos;
  } csi_stat_t;

endpackage

### rtl/core/csi_datapath.sv
// Datapath: stores, multiplier, accumulator, shared square root and divide unit, result register.
`timescale 1ns / 1ps
`include "cholesky_solve_inverse_core_macros.svh"
module csi_datapath import csi_pkg::*; #(
  parameter int MAX_SIZE  = MAX_SIZE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int TRI = MAX_SIZE * (MAX_SIZE + 1) / 2,
  localparam int TW  = $clog2(TRI),
  localparam int VW  = $clog2(MAX_SIZE)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csi_cmd_t           cmd_i,
  input  logic [TW-1:0]      fa_addr_i,
  input  logic [TW-1:0]      fb_addr_i,
  input  logic [TW-1:0]      fw_addr_i,
  input  logic [VW-1:0]      v_raddr_i,
  input  logic [VW-1:0]      v_waddr_i,
  input  logic [TW-1:0]      s_raddr_i,
  input  logic [TW-1:0]      s_waddr_i,
  input  logic [2:0]         row_i,
  input  logic [2:0]         col_i,
  input  logic signed [31:0] value_i,
  output csi_stat_t          stat_o,
  output logic               result_valid_o,
  output logic [1:0]         kind_o,
  output logic [1:0]         status_o,
  output logic [2:0]         out_row_o,
  output logic [2:0]         out_col_o,
  output logic signed [31:0] result_value_o,
  output logic               end_of_run_o
);

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh000000007FFFFFFF) begin
      return Q_MAX;
    end else if (v < -64'sh0000000080000000) begin
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  logic [31:0] f_mem [TRI];
  logic [31:0] v_mem [MAX_SIZE];
  logic [31:0] s_mem [TRI];

  logic signed [31:0] fa_q, fb_q, v_q, s_q;
  logic signed [31:0] wdata;
  logic signed [31:0] res_q;

  assign wdata = cmd_i.wr_input ? value_i : res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.f_we) begin
      f_mem[fw_addr_i] <= wdata;
    end
    if (cmd_i.v_we) begin
      v_mem[v_waddr_i] <= wdata;
    end
    if (cmd_i.s_we) begin
      s_mem[s_waddr_i] <= wdata;
    end
    fa_q <= f_mem[fa_addr_i];
    fb_q <= f_mem[fb_addr_i];
    v_q  <= v_mem[v_raddr_i];
    s_q  <= s_mem[s_raddr_i];
  end

  // Multiplier, accumulator and running determinant.
  logic signed [63:0] prod_q, prod_sh, acc_q, init_val;
  logic signed [31:0] den_q, det_q, y_val, mul_a, mul_b, acc_sat;

  assign prod_sh = prod_q >>> FRAC_BITS;
  assign acc_sat = sat32(acc_q);

  always_comb begin
    case (cmd_i.y_sel)
      Y_FB:    y_val = fb_q;
      Y_V:     y_val = v_q;
      Y_S:     y_val = s_q;
      default: y_val = fb_q;
    endcase
    case (cmd_i.mul_sel)
      MUL_XY: begin
        mul_a = fa_q;
        mul_b = y_val;
      end
      MUL_DET_ROOT: begin
        mul_a = det_q;
        mul_b = res_q;
      end
      MUL_DET_SQ: begin
        mul_a = det_q;
        mul_b = det_q;
      end
      default: begin
        mul_a = fa_q;
        mul_b = y_val;
      end
    endcase
    case (cmd_i.init_sel)
      INIT_FB:    init_val = 64'(fb_q);
      INIT_V:     init_val = 64'(v_q);
      INIT_S:     init_val = 64'(s_q);
      INIT_CONST: init_val = cmd_i.init_one ? (64'sd1 <<< FRAC_BITS) : 64'sd0;
      default:    init_val = 64'(fb_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.acc_load) begin
      acc_q <= init_val;
    end else if (cmd_i.acc_mac) begin
      acc_q <= acc_q - prod_sh;
    end
    if (cmd_i.den_load) begin
      den_q <= fa_q;
    end
    if (cmd_i.det_init) begin
      det_q <= 32'sd1 <<< FRAC_BITS;
    end else if (cmd_i.det_update) begin
      det_q <= sat32(prod_sh);
    end
  end

  // Shared iterative unit: 32-step square root or DW-step restoring divide.
  logic               unit_busy_q, is_root_q, neg_q;
  logic [CW-1:0]      cnt_q;
  logic [63:0]        sq_rem_q, sq_res_q, sq_bit_q, sq_trial;
  logic [63:0]        sq_rem_n, sq_res_n;
  logic [31:0]        dv_rem_q, dv_rem_n, dv_mag;
  logic [DW-1:0]      dv_dd_q, dv_dd_n;
  logic [32:0]        dv_shift;
  logic               dv_ge;
  logic signed [31:0] dv_final;

  always_comb begin
    sq_trial = sq_res_q + sq_bit_q;
    if (sq_rem_q >= sq_trial) begin
      sq_rem_n = sq_rem_q - sq_trial;
      sq_res_n = (sq_res_q >> 1) + sq_bit_q;
    end else begin
      sq_rem_n = sq_rem_q;
      sq_res_n = sq_res_q >> 1;
    end
    dv_shift = {dv_rem_q, dv_dd_q[DW-1]};
    dv_ge    = dv_shift >= {1'b0, den_q};
    dv_rem_n = dv_ge ? 32'(dv_shift - {1'b0, den_q}) : dv_shift[31:0];
    dv_dd_n  = {dv_dd_q[DW-2:0], dv_ge};
    if (!neg_q) begin
      dv_final = (dv_dd_n > DW'(64'h7FFFFFFF)) ? Q_MAX : dv_dd_n[31:0];
    end else begin
      dv_final = (dv_dd_n > DW'(64'h80000000)) ? Q_MIN : -dv_dd_n[31:0];
    end
    dv_mag = acc_sat[31] ? 32'(-acc_sat) : 32'(acc_sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_busy_q <= 1'b0;
      cnt_q       <= '0;
    end else if (cmd_i.root_start) begin
      unit_busy_q <= 1'b1;
      cnt_q       <= CW'(32);
    end else if (cmd_i.div_start) begin
      unit_busy_q <= den_q > 32'sd0;
      cnt_q       <= CW'(DW);
    end else if (unit_busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        unit_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_start) begin
      is_root_q <= 1'b1;
      sq_rem_q  <= {32'b0, acc_sat} << FRAC_BITS;
      sq_res_q  <= '0;
      sq_bit_q  <= 64'd1 << 62;
    end else if (cmd_i.div_start) begin
      is_root_q <= 1'b0;
      neg_q     <= acc_sat[31];
      dv_rem_q  <= '0;
      dv_dd_q   <= DW'(dv_mag) << FRAC_BITS;
      if (den_q <= 32'sd0) begin
        res_q <= acc_sat[31] ? Q_MIN : Q_MAX;
      end
    end else if (unit_busy_q) begin
      if (is_root_q) begin
        sq_rem_q <= sq_rem_n;
        sq_res_q <= sq_res_n;
        sq_bit_q <= sq_bit_q >> 2;
        if (cnt_q == CW'(1)) begin
          res_q <= sq_res_n[31:0];
        end
      end else begin
        dv_rem_q <= dv_rem_n;
        dv_dd_q  <= dv_dd_n;
        if (cnt_q == CW'(1)) begin
          res_q <= dv_final;
        end
      end
    end
  end

  assign stat_o.unit_busy  = unit_busy_q;
  assign stat_o.acc_nonpos = acc_sat <= 32'sd0;

  // Result register: one beat per load.
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_o       <= cmd_i.out_kind;
      status_o     <= cmd_i.out_status;
      out_row_o    <= row_i;
      out_col_o    <= col_i;
      end_of_run_o <= cmd_i.out_end;
      case (cmd_i.out_sel)
        OUT_ZERO: result_value_o <= '0;
        OUT_PROD: result_value_o <= sat32(prod_sh);
        OUT_VEC:  result_value_o <= v_q;
        OUT_INV:  result_value_o <= s_q;
        default:  result_value_o <= '0;
      endcase
    end
  end

  assign result_valid_o = out_valid_q;

  `CSI_ASSERT_IMPL(a_no_store_write_mid_unit, cmd_i.f_we, !unit_busy_q, "factor write while unit busy")

endmodule

### rtl/core/csi_ctrl.sv
// Sequencer: loop counters, address generation and commands for the datapath.
`timescale 1ns / 1ps
`include "cholesky_solve_inverse_core_macros.svh"
module csi_ctrl import csi_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF,
  localparam int TRI = MAX_SIZE * (MAX_SIZE + 1) / 2,
  localparam int TW  = $clog2(TRI),
  localparam int VW  = $clog2(MAX_SIZE),
  localparam int IW  = $clog2(MAX_SIZE + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    operation_i,
  input  logic [2:0]    row_i,
  input  logic [2:0]    col_i,
  input  logic          last_i,
  input  logic          cfg_we_i,
  input  logic [IW-1:0] n_i,
  input  csi_stat_t     stat_i,
  output csi_cmd_t      cmd_o,
  output logic [TW-1:0] fa_addr_o,
  output logic [TW-1:0] fb_addr_o,
  output logic [TW-1:0] fw_addr_o,
  output logic [VW-1:0] v_raddr_o,
  output logic [VW-1:0] v_waddr_o,
  output logic [TW-1:0] s_raddr_o,
  output logic [TW-1:0] s_waddr_o,
  output logic [2:0]    out_row_o,
  output logic [2:0]    out_col_o,
  output logic          busy_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_INIT2 = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_WAIT  = 4'd7;
  localparam logic [3:0] S_WB    = 4'd8;
  localparam logic [3:0] S_DET   = 4'd9;
  localparam logic [3:0] S_DETW  = 4'd10;
  localparam logic [3:0] S_REP   = 4'd11;
  localparam logic [3:0] S_REPW  = 4'd12;
  localparam logic [3:0] S_ERD   = 4'd13;
  localparam logic [3:0] S_EOUT  = 4'd14;

  localparam logic [2:0] M_FD = 3'd0;  // factor diagonal
  localparam logic [2:0] M_FC = 3'd1;  // factor column below diagonal
  localparam logic [2:0] M_SF = 3'd2;  // forward substitution
  localparam logic [2:0] M_SB = 3'd3;  // backward substitution
  localparam logic [2:0] M_IF = 3'd4;  // inverse column, forward
  localparam logic [2:0] M_IB = 3'd5;  // inverse column, backward
  localparam logic [2:0] M_EV = 3'd6;  // emit solution
  localparam logic [2:0] M_ES = 3'd7;  // emit inverse

  function automatic logic [TW-1:0] tri_idx(input logic [IW-1:0] r, input logic [IW-1:0] c);
    logic [TW:0] p;
    p = (TW+1)'(r) * ((TW+1)'(r) + 1'b1);
    return p[TW:1] + TW'(c);
  endfunction

  logic [3:0]    state_q, state_d;
  logic [2:0]    mode_q, mode_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic          valid_q, valid_d;
  logic [IW-1:0] ks, ke, n_m1;
  logic [2:0]    rr, cc;
  logic          accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = state_q != S_IDLE;
  assign n_m1   = n_i - 1'b1;
  assign rr     = (col_i > row_i) ? col_i : row_i;
  assign cc     = (col_i > row_i) ? row_i : col_i;

  always_comb begin
    case (mode_q)
      M_FD, M_FC, M_SF: begin
        ks = '0;
        ke = i_q;
      end
      M_IF: begin
        ks = j_q;
        ke = i_q;
      end
      M_SB, M_IB: begin
        ks = i_q + 1'b1;
        ke = n_i;
      end
      default: begin
        ks = '0;
        ke = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    valid_d = valid_q;
    cmd_o   = '0;

    fa_addr_o = tri_idx(i_q, i_q);
    fb_addr_o = (mode_q == M_FC) ? tri_idx(j_q, i_q) : tri_idx(i_q, i_q);
    fw_addr_o = fb_addr_o;
    v_raddr_o = VW'(i_q);
    v_waddr_o = VW'(i_q);
    s_raddr_o = tri_idx(i_q, j_q);
    s_waddr_o = tri_idx(i_q, j_q);
    out_row_o = '0;
    out_col_o = '0;

    case (mode_q)
      M_FD, M_FC: begin
        cmd_o.init_sel = INIT_FB;
        cmd_o.y_sel    = Y_FB;
      end
      M_SF, M_SB: begin
        cmd_o.init_sel = INIT_V;
        cmd_o.y_sel    = Y_V;
      end
      M_IF: begin
        cmd_o.init_sel = INIT_CONST;
        cmd_o.y_sel    = Y_S;
      end
      default: begin
        cmd_o.init_sel = INIT_S;
        cmd_o.y_sel    = Y_S;
      end
    endcase
    cmd_o.init_one = i_q == j_q;

    if (cfg_we_i) begin
      valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (operation_i)
            OP_LOAD_A: begin
              valid_d = 1'b0;
              if (32'(rr) < MAX_SIZE) begin
                cmd_o.f_we     = 1'b1;
                cmd_o.wr_input = 1'b1;
                fw_addr_o      = tri_idx(IW'(rr), IW'(cc));
              end
              if (last_i) begin
                cmd_o.det_init = 1'b1;
                mode_d  = M_FD;
                i_d     = '0;
                j_d     = '0;
                state_d = S_INIT;
              end
            end
            OP_LOAD_B: begin
              if (32'(row_i) < MAX_SIZE) begin
                cmd_o.v_we     = 1'b1;
                cmd_o.wr_input = 1'b1;
                v_waddr_o      = VW'(row_i);
              end
              if (last_i) begin
                if (valid_q) begin
                  mode_d  = M_SF;
                  i_d     = '0;
                  state_d = S_INIT;
                end else begin
                  cmd_o.out_load   = 1'b1;
                  cmd_o.out_kind   = KIND_SOLUTION;
                  cmd_o.out_status = ST_NO_FACTOR;
                  cmd_o.out_sel    = OUT_ZERO;
                  cmd_o.out_end    = 1'b1;
                end
              end
            end
            OP_INVERSE: begin
              if (valid_q) begin
                mode_d  = M_IF;
                i_d     = '0;
                j_d     = '0;
                state_d = S_INIT;
              end else begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_kind   = KIND_INVERSE;
                cmd_o.out_status = ST_NO_FACTOR;
                cmd_o.out_sel    = OUT_ZERO;
                cmd_o.out_end    = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INIT: begin
        state_d = S_INIT2;
      end
      S_INIT2: begin
        cmd_o.acc_load = 1'b1;
        cmd_o.den_load = 1'b1;
        k_d = ks;
        state_d = (ks < ke) ? S_RD : S_FIN;
      end
      S_RD: begin
        if (mode_q == M_SB || mode_q == M_IB) begin
          fa_addr_o = tri_idx(k_q, i_q);
        end else begin
          fa_addr_o = tri_idx(i_q, k_q);
        end
        fb_addr_o = (mode_q == M_FC) ? tri_idx(j_q, k_q) : tri_idx(i_q, k_q);
        v_raddr_o = VW'(k_q);
        s_raddr_o = tri_idx(k_q, j_q);
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_XY;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_mac = 1'b1;
        k_d = k_q + 1'b1;
        state_d = ((k_q + 1'b1) < ke) ? S_RD : S_FIN;
      end
      S_FIN: begin
        if (mode_q == M_FD) begin
          if (stat_i.acc_nonpos) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_kind   = KIND_REPORT;
            cmd_o.out_status = ST_PIVOT;
            cmd_o.out_sel    = OUT_ZERO;
            cmd_o.out_end    = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.root_start = 1'b1;
            state_d = S_WAIT;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!stat_i.unit_busy) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        state_d = S_INIT;
        case (mode_q)
          M_FD: begin
            cmd_o.f_we = 1'b1;
            state_d = S_DET;
          end
          M_FC: begin
            cmd_o.f_we = 1'b1;
            if ((j_q + 1'b1) < n_i) begin
              j_d = j_q + 1'b1;
            end else begin
              i_d    = i_q + 1'b1;
              mode_d = M_FD;
            end
          end
          M_SF: begin
            cmd_o.v_we = 1'b1;
            if ((i_q + 1'b1) < n_i) begin
              i_d = i_q + 1'b1;
            end else begin
              mode_d = M_SB;
              i_d    = n_m1;
            end
          end
          M_SB: begin
            cmd_o.v_we = 1'b1;
            if (i_q == '0) begin
              mode_d  = M_EV;
              state_d = S_ERD;
            end else begin
              i_d = i_q - 1'b1;
            end
          end
          M_IF: begin
            cmd_o.s_we = 1'b1;
            if ((i_q + 1'b1) < n_i) begin
              i_d = i_q + 1'b1;
            end else begin
              mode_d = M_IB;
              i_d    = n_m1;
            end
          end
          default: begin
            cmd_o.s_we = 1'b1;
            if (i_q == j_q) begin
              if ((j_q + 1'b1) < n_i) begin
                j_d    = j_q + 1'b1;
                i_d    = j_q + 1'b1;
                mode_d = M_IF;
              end else begin
                mode_d  = M_ES;
                i_d     = '0;
                j_d     = '0;
                state_d = S_ERD;
              end
            end else begin
              i_d = i_q - 1'b1;
            end
          end
        endcase
      end
      S_DET: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DET_ROOT;
        state_d = S_DETW;
      end
      S_DETW: begin
        cmd_o.det_update = 1'b1;
        if ((i_q + 1'b1) < n_i) begin
          mode_d  = M_FC;
          j_d     = i_q + 1'b1;
          state_d = S_INIT;
        end else begin
          state_d = S_REP;
        end
      end
      S_REP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DET_SQ;
        state_d = S_REPW;
      end
      S_REPW: begin
        cmd_o.out_load   = 1'b1;
        cmd_o.out_kind   = KIND_REPORT;
        cmd_o.out_status = ST_OK;
        cmd_o.out_sel    = OUT_PROD;
        cmd_o.out_end    = 1'b1;
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      S_ERD: begin
        state_d = S_EOUT;
      end
      S_EOUT: begin
        cmd_o.out_load   = 1'b1;
        cmd_o.out_status = ST_OK;
        out_row_o        = 3'(i_q);
        state_d          = S_ERD;
        if (mode_q == M_EV) begin
          cmd_o.out_kind = KIND_SOLUTION;
          cmd_o.out_sel  = OUT_VEC;
          cmd_o.out_end  = i_q == n_m1;
          if (i_q == n_m1) begin
            state_d = S_IDLE;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          cmd_o.out_kind = KIND_INVERSE;
          cmd_o.out_sel  = OUT_INV;
          out_col_o      = 3'(j_q);
          cmd_o.out_end  = (i_q == n_m1) && (j_q == i_q);
          if (j_q == i_q) begin
            if (i_q == n_m1) begin
              state_d = S_IDLE;
            end else begin
              i_d = i_q + 1'b1;
              j_d = '0;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_FD;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      valid_q <= valid_d;
    end
  end

  `CSI_ASSERT_IMPL(a_start_unit_idle, (cmd_o.root_start || cmd_o.div_start), !stat_i.unit_busy, "unit started while busy")
  `CSI_ASSERT_IMPL(a_valid_after_report, $rose(valid_q), $past(state_q) == S_REPW, "factor valid set outside report")
  `CSI_ASSERT_NEXT(a_end_goes_idle, (cmd_o.out_load && cmd_o.out_end), state_q == S_IDLE, "busy after final beat")

endmodule

### rtl/core/cholesky_solve_inverse_core.sv
// Top level of the Cholesky factorization, solve and inverse core.
`timescale 1ns / 1ps
// A command beat is taken at a clock edge where start is high and busy is low. Matrix and
// right-hand side element loads not marked last leave busy low. The element marked last starts
// the work: factorization runs one element of L at a time; each element reads, multiplies and
// accumulates one product term of its inner sum after another, then passes through the shared
// unit as a square root for a diagonal element or as a divide for any other element. Solve and
// inverse use the same inner-sum and divide sequence, and the shared multiplier and the one
// iterative square root and divide unit set the run length. Solution and inverse beats leave
// one per pass through the read and emit states, each result shown for exactly one cycle with
// result_valid_o high. The receiver cannot stall, so it must take every beat when it appears;
// end_of_run_o marks the final beat of a command. The stores hold undefined data after reset
// and need no clearing pass. The size register at byte address 0 may only be written while
// busy is low; any write to it drops the current factorization.
module cholesky_solve_inverse_core import csi_pkg::*; #(
  parameter int MAX_SIZE  = MAX_SIZE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation_i,
  input  logic [2:0]         row_i,
  input  logic [2:0]         col_i,
  input  logic signed [31:0] value_i,
  input  logic               last_i,
  output logic               result_valid_o,
  output logic [1:0]         kind_o,
  output logic [1:0]         status_o,
  output logic [2:0]         out_row_o,
  output logic [2:0]         out_col_o,
  output logic signed [31:0] result_value_o,
  output logic               end_of_run_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int TRI = MAX_SIZE * (MAX_SIZE + 1) / 2;
  localparam int TW  = $clog2(TRI);
  localparam int VW  = $clog2(MAX_SIZE);
  localparam int IW  = $clog2(MAX_SIZE + 1);

  // Configuration: a single size register; paddr[2] selects the register slot.
  logic [3:0]    size_q;
  logic          cfg_we;
  logic [IW-1:0] order_n;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_SIZE);
  assign prdata = (paddr[2] == REG_SIZE) ? {28'b0, size_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we) begin
      size_q <= pwdata[3:0];
    end
  end

  // A size of zero works as order one, and anything above the built maximum as the maximum.
  always_comb begin
    if (size_q == 4'd0) begin
      order_n = IW'(1);
    end else if (32'(size_q) > MAX_SIZE) begin
      order_n = IW'(MAX_SIZE);
    end else begin
      order_n = IW'(size_q);
    end
  end

  csi_cmd_t      cmd;
  csi_stat_t     stat;
  logic [TW-1:0] fa_addr, fb_addr, fw_addr, s_raddr, s_waddr;
  logic [VW-1:0] v_raddr, v_waddr;
  logic [2:0]    emit_row, emit_col;

  csi_ctrl #(
    .MAX_SIZE (MAX_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .operation_i (operation_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .last_i      (last_i),
    .cfg_we_i    (cfg_we),
    .n_i         (order_n),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .fa_addr_o   (fa_addr),
    .fb_addr_o   (fb_addr),
    .fw_addr_o   (fw_addr),
    .v_raddr_o   (v_raddr),
    .v_waddr_o   (v_waddr),
    .s_raddr_o   (s_raddr),
    .s_waddr_o   (s_waddr),
    .out_row_o   (emit_row),
    .out_col_o   (emit_col),
    .busy_o      (busy)
  );

  csi_datapath #(
    .MAX_SIZE  (MAX_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .fa_addr_i      (fa_addr),
    .fb_addr_i      (fb_addr),
    .fw_addr_i      (fw_addr),
    .v_raddr_i      (v_raddr),
    .v_waddr_i      (v_waddr),
    .s_raddr_i      (s_raddr),
    .s_waddr_i      (s_waddr),
    .row_i          (emit_row),
    .col_i          (emit_col),
    .value_i        (value_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .status_o       (status_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .result_value_o (result_value_o),
    .end_of_run_o   (end_of_run_o)
  );

endmodule

### tb/sv/cholesky_solve_inverse_core_test.sv
// Self-checking testbench for the Cholesky factorization, solve and inverse core.
`timescale 1ns / 1ps
// The bench drives command beats into the core and predicts every result beat with its own
// fixed-point model of the factorization, the two substitutions and the inverse. It starts
// with a short directed table and then runs random sequences of matrix loads, right-hand side
// loads, inverse requests and noise. Most sequences are well formed: a whole lower triangle or
// a whole vector with random content, often diagonally dominant so that the pivots stay
// positive. The size register is rewritten between phases, only when the core is idle.
module cholesky_solve_inverse_core_test;
  import csi_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int MAXN = MAX_SIZE_DEF;
  localparam int TRI = MAXN * (MAXN + 1) / 2;
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;
  localparam longint ONE = 64'sd1 <<< FRAC;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int RANDOM_ITEMS = 250;

  typedef struct {
    kind_e       kind;
    status_e     status;
    logic [2:0]  r;
    logic [2:0]  c;
    logic [31:0] val;
    logic        eor;
  } beat_t;

  // One row of the directed table. A size of -1 leaves the size register alone; a row with
  // typed set carries its single expected beat instead of asking the predictor.
  typedef struct {
    int          sz;
    logic [1:0]  op;
    logic [2:0]  r;
    logic [2:0]  c;
    logic [31:0] v;
    logic        l;
    bit          typed;
    kind_e       k;
    status_e     s;
    logic [31:0] ev;
  } dir_row_t;

  logic clk_i, rst_ni;
  logic start, busy;
  logic [1:0] operation_i;
  logic [2:0] row_i, col_i;
  logic signed [31:0] value_i;
  logic last_i;
  logic result_valid_o;
  logic [1:0] kind_o, status_o;
  logic [2:0] out_row_o, out_col_o;
  logic signed [31:0] result_value_o;
  logic end_of_run_o;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  cholesky_solve_inverse_core uut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .row_i, .col_i, .value_i, .last_i,
    .result_valid_o, .kind_o, .status_o, .out_row_o, .out_col_o, .result_value_o,
    .end_of_run_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Predictor state: its own copy of L, x, the inverse scratch and the size register.
  longint factor_mem[TRI];
  longint vec_mem[MAXN];
  longint inv_mem[TRI];
  bit     factor_ok;
  logic [3:0] size_reg;
  // Which store entries have been written, so that no unwritten entry is ever read.
  bit factor_wr[TRI];
  bit vec_wr[MAXN];

  beat_t expected_beats[$];
  beat_t step_beats[$];
  int    mismatches;
  int    cycles;
  int    items;
  int    idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog on a slowest-case run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Every result beat is compared against the oldest pending expectation.
  always @(posedge clk_i) begin
    beat_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat kind %0d status %0d row %0d col %0d value %h",
                 $time, kind_o, status_o, out_row_o, out_col_o, result_value_o);
        mismatches++;
      end else begin
        e = expected_beats.pop_front();
        if (kind_o !== e.kind || status_o !== e.status || out_row_o !== e.r ||
            out_col_o !== e.c || result_value_o !== e.val || end_of_run_o !== e.eor) begin
          $display("%0t: expected kind %0d status %0d row %0d col %0d value %h end %0d",
                   $time, e.kind, e.status, e.r, e.c, e.val, e.eor);
          $display("%0t:   actual kind %0d status %0d row %0d col %0d value %h end %0d",
                   $time, kind_o, status_o, out_row_o, out_col_o, result_value_o,
                   end_of_run_o);
          mismatches++;
        end
      end
    end
  end

  function automatic int tri_idx(int r, int c);
    return r * (r + 1) / 2 + c;
  endfunction

  function automatic int order_n();
    if (size_reg == 0) return 1;
    if (size_reg > MAXN) return MAXN;
    return int'(size_reg);
  endfunction

  function automatic longint sat32(longint x);
    if (x > MAX32) return MAX32;
    if (x < MIN32) return MIN32;
    return x;
  endfunction

  // Product with the fraction bits dropped, rounding toward minus infinity.
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  // Quotient truncated toward zero and saturated; a non-positive divisor saturates.
  function automatic longint fx_div(longint num, longint den);
    longint unsigned mag;
    longint unsigned q;
    if (den <= 0) return (num < 0) ? MIN32 : MAX32;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag << FRAC) / longint'(den);
    if (num >= 0) return (q > longint'(MAX32)) ? MAX32 : longint'(q);
    if (q > (64'd1 << 31)) return MIN32;
    return -longint'(q);
  endfunction

  // Bit-serial integer square root of s shifted up by the fraction bits.
  function automatic longint fx_sqrt(longint s);
    longint unsigned rem, res, bitv;
    rem = longint'(s) << FRAC;
    res = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic void add_beat(kind_e k, status_e s, int r, int c, longint v);
    beat_t b;
    b.kind = k;
    b.status = s;
    b.r = r[2:0];
    b.c = c[2:0];
    b.val = v[31:0];
    b.eor = 1'b0;
    step_beats.push_back(b);
  endfunction

  function automatic void factorize();
    int n;
    longint det, sum, diag, s;
    n = order_n();
    det = ONE;
    factor_ok = 0;
    for (int i = 0; i < n; i++) begin
      sum = factor_mem[tri_idx(i, i)];
      for (int k = 0; k < i; k++)
        sum -= fx_mul(factor_mem[tri_idx(i, k)], factor_mem[tri_idx(i, k)]);
      sum = sat32(sum);
      if (sum <= 0) begin
        add_beat(KIND_REPORT, ST_PIVOT, 0, 0, 0);
        return;
      end
      diag = fx_sqrt(sum);
      factor_mem[tri_idx(i, i)] = diag;
      for (int j = i + 1; j < n; j++) begin
        s = factor_mem[tri_idx(j, i)];
        for (int k = 0; k < i; k++)
          s -= fx_mul(factor_mem[tri_idx(i, k)], factor_mem[tri_idx(j, k)]);
        factor_mem[tri_idx(j, i)] = fx_div(sat32(s), diag);
      end
    end
    for (int i = 0; i < n; i++) det = sat32(fx_mul(det, factor_mem[tri_idx(i, i)]));
    factor_ok = 1;
    add_beat(KIND_REPORT, ST_OK, 0, 0, sat32(fx_mul(det, det)));
  endfunction

  // Forward substitution with L, then backward substitution with L transposed.
  function automatic void solve_system();
    int n;
    longint s;
    n = order_n();
    if (!factor_ok) begin
      add_beat(KIND_SOLUTION, ST_NO_FACTOR, 0, 0, 0);
      return;
    end
    for (int i = 0; i < n; i++) begin
      s = vec_mem[i];
      for (int k = 0; k < i; k++) s -= fx_mul(factor_mem[tri_idx(i, k)], vec_mem[k]);
      vec_mem[i] = fx_div(sat32(s), factor_mem[tri_idx(i, i)]);
    end
    for (int i = n - 1; i >= 0; i--) begin
      s = vec_mem[i];
      for (int k = i + 1; k < n; k++) s -= fx_mul(factor_mem[tri_idx(k, i)], vec_mem[k]);
      vec_mem[i] = fx_div(sat32(s), factor_mem[tri_idx(i, i)]);
    end
    for (int i = 0; i < n; i++) add_beat(KIND_SOLUTION, ST_OK, i, 0, vec_mem[i]);
  endfunction

  // Column by column: solve L y = e_j, then L^T z = y, keeping only the lower part.
  function automatic void invert_matrix();
    int n;
    longint s;
    n = order_n();
    if (!factor_ok) begin
      add_beat(KIND_INVERSE, ST_NO_FACTOR, 0, 0, 0);
      return;
    end
    for (int j = 0; j < n; j++) begin
      for (int i = j; i < n; i++) begin
        s = (i == j) ? ONE : 0;
        for (int k = j; k < i; k++)
          s -= fx_mul(factor_mem[tri_idx(i, k)], inv_mem[tri_idx(k, j)]);
        inv_mem[tri_idx(i, j)] = fx_div(sat32(s), factor_mem[tri_idx(i, i)]);
      end
      for (int i = n - 1; i >= j; i--) begin
        s = inv_mem[tri_idx(i, j)];
        for (int k = i + 1; k < n; k++)
          s -= fx_mul(factor_mem[tri_idx(k, i)], inv_mem[tri_idx(k, j)]);
        inv_mem[tri_idx(i, j)] = fx_div(sat32(s), factor_mem[tri_idx(i, i)]);
      end
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j <= i; j++) add_beat(KIND_INVERSE, ST_OK, i, j, inv_mem[tri_idx(i, j)]);
  endfunction

  // Updates the predictor for one accepted command and leaves its beats in step_beats.
  function automatic void predict_command(logic [1:0] op, logic [2:0] r, logic [2:0] c,
                                          logic [31:0] v, logic l);
    int rr, cc;
    step_beats.delete();
    rr = (c > r) ? int'(c) : int'(r);
    cc = (c > r) ? int'(r) : int'(c);
    case (op)
      OP_LOAD_A: begin
        factor_mem[tri_idx(rr, cc)] = longint'(signed'(v));
        factor_wr[tri_idx(rr, cc)] = 1;
        factor_ok = 0;
        if (l) factorize();
      end
      OP_LOAD_B: begin
        vec_mem[r] = longint'(signed'(v));
        vec_wr[r] = 1;
        if (l) solve_system();
      end
      OP_INVERSE: invert_matrix();
      default: ;
    endcase
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].eor = 1'b1;
  endfunction

  // Drives one command beat at the falling edge and holds it until the core takes it.
  // busy only changes at a rising edge, so a low busy seen at the falling edge means the
  // beat is taken at the next rising edge.
  task automatic send_command(logic [1:0] op, logic [2:0] r, logic [2:0] c, logic [31:0] v,
                              logic l, bit typed = 0,
                              beat_t typed_beat = '{kind: KIND_REPORT, status: ST_OK,
                                                    default: 0});
    @(negedge clk_i);
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    operation_i = op;
    row_i = r;
    col_i = c;
    value_i = v;
    last_i = l;
    start = 1'b1;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    predict_command(op, r, c, v, l);
    if (typed) expected_beats.push_back(typed_beat);
    else foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
    if (op != OP_IGNORED) items++;
  endtask

  // Waits until every expected beat has arrived and the core has gone quiet.
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_beats.size() != 0 || busy) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the write lands on the edge with pready high.
  task automatic write_size(logic [3:0] sz);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 3'(4 * REG_SIZE);
    pwdata = 32'(sz);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    size_reg = sz;
    factor_ok = 0;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic bit triangle_written();
    for (int i = 0; i < tri_idx(order_n(), 0); i++) if (!factor_wr[i]) return 0;
    return 1;
  endfunction

  function automatic bit vector_written();
    for (int i = 0; i < order_n(); i++) if (!vec_wr[i]) return 0;
    return 1;
  endfunction

  // Loads the whole lower triangle in shuffled order, some elements given from the upper
  // side. A dominant diagonal keeps the matrix positive definite; otherwise content is raw.
  task automatic load_matrix(bit dominant);
    int n, cnt, t, sh;
    int rs[TRI], cs[TRI];
    longint scale, val;
    n = order_n();
    cnt = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j <= i; j++) begin
        rs[cnt] = i;
        cs[cnt] = j;
        cnt++;
      end
    for (int i = cnt - 1; i > 0; i--) begin
      t = $urandom_range(0, i);
      {rs[i], rs[t]} = {rs[t], rs[i]};
      {cs[i], cs[t]} = {cs[t], cs[i]};
    end
    sh = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 15) : $urandom_range(16, 20);
    scale = 64'sd1 <<< sh;
    for (int e = 0; e < cnt; e++) begin
      if (!dominant) val = longint'(signed'(32'($urandom())));
      else if (rs[e] == cs[e]) val = n * scale + $urandom_range(0, int'(scale));
      else val = longint'($urandom_range(0, 2 * int'(scale))) - scale;
      if (rs[e] != cs[e] && $urandom_range(0, 2) == 0)
        send_command(OP_LOAD_A, 3'(cs[e]), 3'(rs[e]), val[31:0], e == cnt - 1);
      else
        send_command(OP_LOAD_A, 3'(rs[e]), 3'(cs[e]), val[31:0], e == cnt - 1);
    end
  endtask

  task automatic load_vector();
    int n, t;
    int idx[MAXN];
    n = order_n();
    for (int i = 0; i < n; i++) idx[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      t = $urandom_range(0, i);
      {idx[i], idx[t]} = {idx[t], idx[i]};
    end
    for (int i = 0; i < n; i++)
      send_command(OP_LOAD_B, 3'(idx[i]), 3'($urandom()),
                   ($urandom_range(0, 7) == 0) ? 32'($urandom())
                                               : 32'($urandom_range(0, 1 << 22)) - (1 << 21),
                   i == n - 1);
  endtask

  // A stray command; last is only kept where it cannot read an unwritten entry.
  task automatic noise_command();
    logic [1:0] op;
    logic [2:0] r, c;
    logic l;
    op = 2'($urandom());
    r = 3'($urandom());
    c = 3'($urandom());
    l = 1'($urandom());
    if (op == OP_LOAD_A && l) begin
      // The element itself is written before the factorization reads the triangle.
      factor_wr[tri_idx((c > r) ? int'(c) : int'(r), (c > r) ? int'(r) : int'(c))] = 1;
      l = triangle_written();
    end
    if (op == OP_LOAD_B && l && factor_ok) begin
      vec_wr[r] = 1;
      l = vector_written();
    end
    send_command(op, r, c, 32'($urandom()), l);
  endtask

  // Directed table: no-factor errors at reset size, the ignored opcode, an upper element,
  // then size 1 with unit values, zero and negative pivots and value extremes.
  dir_row_t directed[17] = '{
    '{-1, OP_INVERSE, 3'd0, 3'd0, 32'h0, 1'b0, 1, KIND_INVERSE, ST_NO_FACTOR, 32'h0},
    '{-1, OP_LOAD_B, 3'd7, 3'd7, 32'h7fffffff, 1'b1, 1, KIND_SOLUTION, ST_NO_FACTOR, 32'h0},
    '{-1, OP_IGNORED, 3'd7, 3'd7, 32'hffffffff, 1'b1, 0, KIND_REPORT, ST_OK, 32'h0},
    '{-1, OP_LOAD_A, 3'd0, 3'd7, 32'h80000000, 1'b0, 0, KIND_REPORT, ST_OK, 32'h0},
    '{1, OP_LOAD_A, 3'd0, 3'd0, 32'h00010000, 1'b1, 1, KIND_REPORT, ST_OK, 32'h00010000},
    '{-1, OP_LOAD_B, 3'd0, 3'd0, 32'h00010000, 1'b1, 1, KIND_SOLUTION, ST_OK, 32'h00010000},
    '{-1, OP_INVERSE, 3'd0, 3'd0, 32'h0, 1'b0, 1, KIND_INVERSE, ST_OK, 32'h00010000},
    '{-1, OP_LOAD_A, 3'd0, 3'd0, 32'h0, 1'b1, 1, KIND_REPORT, ST_PIVOT, 32'h0},
    '{-1, OP_LOAD_B, 3'd0, 3'd0, 32'h5, 1'b1, 1, KIND_SOLUTION, ST_NO_FACTOR, 32'h0},
    '{-1, OP_LOAD_A, 3'd0, 3'd0, 32'h80000000, 1'b1, 1, KIND_REPORT, ST_PIVOT, 32'h0},
    '{-1, OP_LOAD_A, 3'd0, 3'd0, 32'h7fffffff, 1'b1, 0, KIND_REPORT, ST_OK, 32'h0},
    '{-1, OP_LOAD_B, 3'd0, 3'd0, 32'h80000000, 1'b1, 0, KIND_REPORT, ST_OK, 32'h0},
    '{-1, OP_LOAD_B, 3'd0, 3'd0, 32'h7fffffff, 1'b1, 0, KIND_REPORT, ST_OK, 32'h0},
    '{-1, OP_INVERSE, 3'd0, 3'd0, 32'h0, 1'b0, 0, KIND_REPORT, ST_OK, 32'h0},
    '{-1, OP_LOAD_A, 3'd0, 3'd0, 32'h00000001, 1'b1, 0, KIND_REPORT, ST_OK, 32'h0},
    '{-1, OP_INVERSE, 3'd0, 3'd0, 32'h0, 1'b0, 0, KIND_REPORT, ST_OK, 32'h0},
    '{-1, OP_LOAD_B, 3'd0, 3'd0, 32'hffff0000, 1'b1, 0, KIND_REPORT, ST_OK, 32'h0}
  };

  // Size settings walked by the random part, extremes included; 0 acts as 1, 15 as 8.
  logic [3:0] size_plan[11] = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd0, 4'd5, 4'd2, 4'd8, 4'd4, 4'd6,
                                4'd7};

  initial begin
    beat_t tb;
    int plan_idx, next_cfg, pick;
    rst_ni = 1'b0;
    start = 1'b0;
    operation_i = OP_LOAD_A;
    row_i = 3'd0;
    col_i = 3'd0;
    value_i = 32'sd0;
    last_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    mismatches = 0;
    cycles = 0;
    items = 0;
    idle_pct = 0;
    factor_ok = 0;
    size_reg = SIZE_RESET;
    foreach (factor_mem[i]) begin
      factor_mem[i] = 0;
      inv_mem[i] = 0;
      factor_wr[i] = 0;
    end
    foreach (vec_mem[i]) begin
      vec_mem[i] = 0;
      vec_wr[i] = 0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].sz >= 0) begin
        drain();
        write_size(4'(directed[i].sz));
      end
      tb.kind = directed[i].k;
      tb.status = directed[i].s;
      tb.r = 3'd0;
      tb.c = 3'd0;
      tb.val = directed[i].ev;
      tb.eor = 1'b1;
      send_command(directed[i].op, directed[i].r, directed[i].c, directed[i].v,
                   directed[i].l, directed[i].typed, tb);
    end

    // Random part: sender idles 25 percent, then 56 percent, then not at all.
    items = 0;
    plan_idx = 0;
    next_cfg = 0;
    while (items < RANDOM_ITEMS) begin
      idle_pct = (items < RANDOM_ITEMS / 3) ? 25 : (items < 2 * RANDOM_ITEMS / 3) ? 56 : 0;
      if (items >= next_cfg) begin
        // Holding off until every expected beat is back also gives the idle-only window
        // in which the size register may change.
        drain();
        write_size(size_plan[plan_idx % 11]);
        plan_idx++;
        next_cfg = items + 25;
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        load_matrix(1);
        if ($urandom_range(0, 2) != 0) load_vector();
        if ($urandom_range(0, 2) == 0) send_command(OP_INVERSE, 3'($urandom()),
                                                    3'($urandom()), 32'($urandom()),
                                                    1'($urandom()));
      end else if (pick == 5) begin
        load_matrix(0);
      end else if (pick < 8) begin
        load_vector();
      end else if (pick == 8) begin
        send_command(OP_INVERSE, 3'($urandom()), 3'($urandom()), 32'($urandom()),
                     1'($urandom()));
      end else begin
        repeat ($urandom_range(1, 3)) noise_command();
      end
    end

    drain();
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
